// File: sv/bf5_pkg.sv
package bf5_pkg;

	localparam int CfgWidthW = 11;
	localparam int CfgHeightW = 13;
	localparam int CfgDataW = 13;

	localparam logic [CfgWidthW-1:0] WidthReset = 11'd1024;
	localparam logic [CfgHeightW-1:0] HeightReset = 13'd768;

	localparam logic RegWidth = 1'b0;
	localparam logic RegHeight = 1'b1;

	localparam int SpaceDen = 25;
	localparam int RangeDen = 2500;
	localparam int WeightW = 16;
	localparam int SpaceRomDepth = 19;
	localparam int SIdxW = 5;

	typedef logic [SpaceRomDepth-1:0][WeightW-1:0] space_rom_t;
	typedef logic [255:0][WeightW-1:0] range_rom_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic rd_centre;
		logic rd_inside;
		logic [SIdxW-1:0] rd_sidx;
		logic clear;
		logic div_start;
		logic load_out;
		logic last;
	} bf5_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_busy;
		logic out_valid;
	} bf5_status_t;

	// Long division by shift and subtract; it only runs while the weight tables are built.
	function automatic logic [63:0] div_u64(logic [63:0] a, logic [63:0] b);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem = rem - {1'b0, b};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-num/den) in Q0.16: Taylor series on x/256 in Q30, then squared eight times.
	function automatic logic [WeightW-1:0] exp_neg_q16(logic [63:0] num, logic use_range);
		logic [63:0] y;
		logic [63:0] acc;
		logic [63:0] term;
		logic [63:0] q;
		if (use_range) begin
			y = div_u64(num << 30, 64'(RangeDen) << 8);
		end else begin
			y = div_u64(num << 30, 64'(SpaceDen) << 8);
		end
		acc = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 10; k++) begin
			term = div_u64((term * y) >> 30, 64'(k));
			if ((k & 1) != 0) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		for (int s = 0; s < 8; s++) begin
			acc = (acc * acc + (64'd1 << 29)) >> 30;
		end
		q = (acc + (64'd1 << 13)) >> 14;
		return (q > 64'd65535) ? 16'hFFFF : q[WeightW-1:0];
	endfunction

	function automatic space_rom_t build_space_rom();
		space_rom_t rom;
		for (int d = 0; d < SpaceRomDepth; d++) begin
			rom[d] = exp_neg_q16(64'(d), 1'b0);
		end
		return rom;
	endfunction

	function automatic range_rom_t build_range_rom();
		range_rom_t rom;
		for (int d = 0; d < 256; d++) begin
			rom[d] = exp_neg_q16(64'(d * d), 1'b1);
		end
		return rom;
	endfunction

	localparam space_rom_t SpaceRom = build_space_rom();
	localparam range_rom_t RangeRom = build_range_rom();

endpackage

// File: sv/bf5_ram.sv
module bf5_ram #(
	parameter int Width = 8,
	parameter int Depth = 4101
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/bf5_datapath.sv
module bf5_datapath #(
	parameter int Depth = 4101,
	parameter int Taps = 25
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bf5_pkg::bf5_cmd_t        cmd,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [$clog2(Depth)-1:0] raddr,
	input  logic [7:0]               pixel_value,
	input  logic                     out_ready,
	output bf5_pkg::bf5_status_t     status,
	output logic                     out_valid,
	output logic [7:0]               filtered_value,
	output logic                     frame_last
);

	localparam int WsumW = $clog2(Taps * 65535 + 1);
	localparam int AccW = WsumW + 8;

	logic [7:0] rdata;

	bf5_ram #(.Width(8), .Depth(Depth)) u_row_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (pixel_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic v_s1, centre_s1, inside_s1;
	logic [bf5_pkg::SIdxW-1:0] sidx_s1;
	logic [7:0] centre_q;
	logic [7:0] dp;
	logic v_s2, v_s3;
	logic [bf5_pkg::WeightW-1:0] sw_s2, rw_s2, prod_s3;
	logic [7:0] pix_s2, pix_s3;
	logic [WsumW-1:0] wsum_q;
	logic [AccW-1:0] acc_q;
	logic div_busy_q;
	logic [2:0] cnt_q;
	logic [AccW-1:0] rem_q, dsh_q;
	logic [7:0] quo_q;
	logic out_valid_q;

	assign dp = (rdata >= centre_q) ? (rdata - centre_q) : (centre_q - rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1 & inside_s1 & ~centre_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		centre_s1 <= cmd.rd_centre;
		inside_s1 <= cmd.rd_inside;
		sidx_s1 <= cmd.rd_sidx;
		if (v_s1 && centre_s1) begin
			centre_q <= rdata;
		end
		sw_s2 <= bf5_pkg::SpaceRom[sidx_s1];
		rw_s2 <= bf5_pkg::RangeRom[dp];
		pix_s2 <= rdata;
		prod_s3 <= 16'((32'(sw_s2) * 32'(rw_s2) + 32'd32768) >> 16);
		pix_s3 <= pix_s2;
		if (cmd.clear) begin
			wsum_q <= '0;
			acc_q <= '0;
		end else if (v_s3) begin
			wsum_q <= wsum_q + WsumW'(prod_s3);
			acc_q <= acc_q + AccW'(24'(prod_s3) * 24'(pix_s3));
		end
	end

	// Restoring division, one quotient bit per cycle; the mean never exceeds 255.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (div_busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= acc_q;
			dsh_q <= AccW'({wsum_q, 7'b0});
		end else if (div_busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				quo_q <= {quo_q[6:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			filtered_value <= (wsum_q == '0) ? 8'd0 : quo_q;
			frame_last <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign status.pipe_busy = v_s1 | v_s2 | v_s3;
	assign status.div_busy = div_busy_q;
	assign status.out_valid = out_valid_q;

endmodule

// File: sv/bf5_ctrl.sv
module bf5_ctrl #(
	parameter int MaxWidth = 1024,
	parameter int MaxHeight = 4096,
	parameter int Radius = 2,
	parameter int Depth = 4101
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic                              wr_index,
	input  logic [bf5_pkg::CfgDataW-1:0]      wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic                              out_ready,
	input  bf5_pkg::bf5_status_t              status,
	output bf5_pkg::bf5_cmd_t                 cmd,
	output logic [$clog2(Depth)-1:0]          ram_waddr,
	output logic [$clog2(Depth)-1:0]          ram_raddr
);

	localparam int AW = $clog2(Depth);
	localparam int WW = $clog2(MaxWidth + 1);
	localparam int HW = $clog2(MaxHeight + 1);
	localparam int NW = $clog2(MaxWidth * MaxHeight + Radius * MaxWidth + Radius + 1);
	localparam int TW = $clog2(2 * Radius + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CENTRE = 3'd1;
	localparam logic [2:0] S_TAPS = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_DIVIDE = 3'd4;
	localparam logic [2:0] S_LOAD = 3'd5;

	logic [2:0] state_q;
	logic [bf5_pkg::CfgWidthW-1:0] width_q;
	logic [bf5_pkg::CfgHeightW-1:0] height_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [NW-1:0] frame, lead, total;
	logic [NW-1:0] n_q;
	logic [AW-1:0] waddr_q, ka_q;
	logic [WW-1:0] ox_q;
	logic [HW-1:0] oy_q;
	logic [TW-1:0] ti_q, tj_q, di, dj;
	logic [AW:0] off_q;
	logic [WW+1:0] tx_q;
	logic [HW+1:0] ty_q;
	logic last_q;
	logic [AW+1:0] sum;
	logic [AW+1:0] sum_wrapped;
	logic in_acc, pixel_slot, drain_early, produce, load;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MaxWidth) begin
			w_eff = WW'(MaxWidth);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MaxHeight) begin
			h_eff = HW'(MaxHeight);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign frame = NW'(w_eff) * NW'(h_eff);
	assign lead = NW'(Radius) * NW'(w_eff) + NW'(Radius);
	assign total = frame + lead;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid & in_ready;
	assign pixel_slot = (n_q < frame);
	assign drain_early = pixel_slot & action;
	assign produce = ~drain_early & (n_q >= lead);
	assign load = (state_q == S_LOAD) & (~status.out_valid | out_ready);

	// Neighbour address is the centre address plus a signed offset, folded into the store.
	assign sum = {2'b00, ka_q} + {off_q[AW], off_q};
	always_comb begin
		if (sum[AW+1]) begin
			sum_wrapped = sum + (AW+2)'(Depth);
		end else if (sum >= (AW+2)'(Depth)) begin
			sum_wrapped = sum - (AW+2)'(Depth);
		end else begin
			sum_wrapped = sum;
		end
	end

	assign di = (ti_q >= TW'(Radius)) ? (ti_q - TW'(Radius)) : (TW'(Radius) - ti_q);
	assign dj = (tj_q >= TW'(Radius)) ? (tj_q - TW'(Radius)) : (TW'(Radius) - tj_q);

	assign ram_waddr = waddr_q;
	assign ram_raddr = (state_q == S_CENTRE) ? ka_q : sum_wrapped[AW-1:0];

	always_comb begin
		cmd = '0;
		cmd.wr_en = in_acc & pixel_slot & ~action;
		cmd.clear = in_acc & produce;
		case (state_q)
			S_CENTRE: begin
				cmd.rd_en = 1'b1;
				cmd.rd_centre = 1'b1;
			end
			S_TAPS: begin
				cmd.rd_en = 1'b1;
				cmd.rd_inside = ~tx_q[WW+1] & (tx_q[WW:0] < {1'b0, w_eff})
					& ~ty_q[HW+1] & (ty_q[HW:0] < {1'b0, h_eff});
				cmd.rd_sidx = bf5_pkg::SIdxW'(bf5_pkg::SIdxW'(di) * bf5_pkg::SIdxW'(di)
					+ bf5_pkg::SIdxW'(dj) * bf5_pkg::SIdxW'(dj));
			end
			S_FLUSH: begin
				cmd.div_start = ~status.pipe_busy;
			end
			S_LOAD: begin
				cmd.load_out = load;
				cmd.last = last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= bf5_pkg::WidthReset;
			height_q <= bf5_pkg::HeightReset;
			n_q <= '0;
			waddr_q <= '0;
			ka_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			ti_q <= '0;
			tj_q <= '0;
			off_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cmd.wr_en) begin
							waddr_q <= (waddr_q == AW'(Depth - 1)) ? '0 : waddr_q + AW'(1);
						end
						if (!drain_early) begin
							if (produce) begin
								state_q <= S_CENTRE;
								last_q <= (n_q == total - NW'(1));
							end else begin
								n_q <= n_q + NW'(1);
							end
						end
					end
				end
				S_CENTRE: begin
					ti_q <= '0;
					tj_q <= '0;
					off_q <= '0 - (AW+1)'(lead);
					tx_q <= (WW+2)'(ox_q) - (WW+2)'(Radius);
					ty_q <= (HW+2)'(oy_q) - (HW+2)'(Radius);
					state_q <= S_TAPS;
				end
				S_TAPS: begin
					if (tj_q == TW'(2 * Radius)) begin
						tj_q <= '0;
						ti_q <= ti_q + TW'(1);
						off_q <= off_q + (AW+1)'(w_eff) - (AW+1)'(2 * Radius);
						tx_q <= (WW+2)'(ox_q) - (WW+2)'(Radius);
						ty_q <= ty_q + (HW+2)'(1);
						if (ti_q == TW'(2 * Radius)) begin
							state_q <= S_FLUSH;
						end
					end else begin
						tj_q <= tj_q + TW'(1);
						off_q <= off_q + (AW+1)'(1);
						tx_q <= tx_q + (WW+2)'(1);
					end
				end
				S_FLUSH: begin
					if (!status.pipe_busy) begin
						state_q <= S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					if (!status.div_busy) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (load) begin
						state_q <= S_IDLE;
						if (last_q) begin
							n_q <= '0;
							waddr_q <= '0;
							ka_q <= '0;
							ox_q <= '0;
							oy_q <= '0;
						end else begin
							n_q <= n_q + NW'(1);
							ka_q <= (ka_q == AW'(Depth - 1)) ? '0 : ka_q + AW'(1);
							if (ox_q == w_eff - WW'(1)) begin
								ox_q <= '0;
								oy_q <= oy_q + HW'(1);
							end else begin
								ox_q <= ox_q + WW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A register write restarts the stream at the first pixel of a frame.
			if (wr_en) begin
				if (wr_index == bf5_pkg::RegWidth) begin
					width_q <= wr_data[bf5_pkg::CfgWidthW-1:0];
				end else begin
					height_q <= wr_data;
				end
				n_q <= '0;
				waddr_q <= '0;
				ka_q <= '0;
				ox_q <= '0;
				oy_q <= '0;
			end
		end
	end

endmodule

// File: sv/bilateral_filter_5x5_top.sv
// Streaming bilateral filter over a (2*RADIUS+1) square window of 8-bit grey pixels.
// Input requests carry action and pixel_value on in_valid/in_ready; pixels arrive in
// raster order and after the last pixel of a frame the sender issues drain requests
// (action = 1) to flush the remaining results. Result requests carry filtered_value
// and frame_last on out_valid/out_ready.
// Result k of a frame comes out on the request RADIUS*width + RADIUS after pixel k.
// A request that gives a result holds the block: the centre and then the taps are read,
// one tap per cycle, from the single read port of the row store, and after the pipeline
// drains a restoring divider forms the mean.
// The next request is accepted while a result waits in the output register; if the
// receiver stalls, the following result holds the block until the register frees.
// Reset clears the stream position and sets width 1024 and height 768; the row store
// is not cleared and needs no clearing pass. Writing width (index 0) or height
// (index 1) through wr_en/wr_index/wr_data restarts the frame; write only while idle.
module bilateral_filter_5x5_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int RADIUS = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [bf5_pkg::CfgDataW-1:0]  wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [7:0]                    pixel_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    filtered_value,
	output logic                          frame_last
);

	localparam int Depth = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
	localparam int AW = $clog2(Depth);
	localparam int Taps = (2 * RADIUS + 1) * (2 * RADIUS + 1);

	bf5_pkg::bf5_cmd_t cmd;
	bf5_pkg::bf5_status_t status;
	logic [AW-1:0] ram_waddr, ram_raddr;

	bf5_ctrl #(
		.MaxWidth  (MAX_WIDTH),
		.MaxHeight (MAX_HEIGHT),
		.Radius    (RADIUS),
		.Depth     (Depth)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	bf5_datapath #(
		.Depth (Depth),
		.Taps  (Taps)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.waddr          (ram_waddr),
		.raddr          (ram_raddr),
		.pixel_value    (pixel_value),
		.out_ready      (out_ready),
		.status         (status),
		.out_valid      (out_valid),
		.filtered_value (filtered_value),
		.frame_last     (frame_last)
	);

`ifndef SYNTH
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(status.pipe_busy || status.div_busy))
		else $error("input accepted while a window is still in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken result");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> status.div_busy)
		else $error("divider did not start");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int HistDepth = 2 * 2 * 1024 + 5;
	localparam int CycleLimit = 2000000;
	localparam int SettleCycles = 60;

	typedef struct {
		logic [7:0] value;
		logic last;
	} pix_out_t;

	typedef struct {
		bit cfg;
		logic idx;
		int data;
		logic act;
		logic [7:0] pix;
		bit typed;
		logic [7:0] exp_value;
		logic exp_last;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic wr_index = bf5_pkg::RegWidth;
	logic [bf5_pkg::CfgDataW-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [7:0] pixel_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] filtered_value;
	logic frame_last;

	bilateral_filter_5x5_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.filtered_value(filtered_value), .frame_last(frame_last)
	);

	always #2 clk = ~clk;

	// Predictor state.
	logic [10:0] width_reg = 11'd1024;
	logic [12:0] height_reg = 13'd768;
	int unsigned frame_pos = 0;
	logic [7:0] pixel_hist [HistDepth];
	int unsigned space_w [9];
	int unsigned range_w [256];

	pix_out_t pending_pix [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	function automatic int unsigned gauss_q16(longint unsigned num, longint unsigned den);
		longint unsigned y, acc, term, q;
		y = (num << 30) / (den << 8);
		acc = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * y) >> 30) / k;
			if (k % 2 == 1) acc = acc - term;
			else acc = acc + term;
		end
		for (int s = 0; s < 8; s++) acc = (acc * acc + (64'd1 << 29)) >> 30;
		q = (acc + (64'd1 << 13)) >> 14;
		return (q > 65535) ? 65535 : int'(q);
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		return (width_reg > 1024) ? 1024 : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		return (height_reg > 4096) ? 4096 : height_reg;
	endfunction

	// Advances the stream by one accepted request; returns 1 when it yields a pixel.
	function automatic bit filter_predict(input logic act, input logic [7:0] pix,
			output pix_out_t res);
		int unsigned w, h, frame, lead, total, n, k, ox, oy, centre, v, dp, prod;
		longint unsigned acc, wsum, q;
		int ty, tx;
		w = eff_width();
		h = eff_height();
		frame = w * h;
		lead = 2 * w + 2;
		total = frame + lead;
		n = frame_pos;
		acc = 0;
		wsum = 0;
		if (n >= total) n = 0;
		if (n < frame) begin
			// A drain request before the frame is complete changes nothing.
			if (act) begin
				frame_pos = n;
				return 0;
			end
			pixel_hist[n % HistDepth] = pix;
		end
		if (n < lead) begin
			frame_pos = n + 1;
			return 0;
		end
		k = n - lead;
		ox = k % w;
		oy = k / w;
		centre = pixel_hist[k % HistDepth];
		for (int i = -2; i <= 2; i++) begin
			for (int j = -2; j <= 2; j++) begin
				ty = int'(oy) + i;
				tx = int'(ox) + j;
				if (ty < 0 || tx < 0 || ty >= int'(h) || tx >= int'(w)) continue;
				v = pixel_hist[(ty * w + tx) % HistDepth];
				dp = (v >= centre) ? v - centre : centre - v;
				prod = (space_w[i * i + j * j] * range_w[dp] + 32768) >> 16;
				wsum += prod;
				acc += longint'(prod) * v;
			end
		end
		q = (wsum == 0) ? 0 : acc / wsum;
		res.value = (q > 255) ? 8'd255 : q[7:0];
		res.last = (k == frame - 1);
		n++;
		frame_pos = (n >= total) ? 0 : n;
		return 1;
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input int data);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data[bf5_pkg::CfgDataW-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == bf5_pkg::RegWidth) width_reg = data[10:0];
		else height_reg = data[12:0];
		frame_pos = 0;
	endtask

	// Sends one request; a typed expectation, if given, replaces the predicted one or is queued when none is predicted.
	task automatic put(input logic act, input logic [7:0] pix, input bit typed = 0,
			input pix_out_t typed_res = '{8'd0, 1'b0});
		pix_out_t res;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			if (in_valid) in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pixel_value <= pix;
		do @(posedge clk); while (!in_ready);
		if (filter_predict(act, pix, res)) pending_pix.push_back(typed ? typed_res : res);
		else if (typed) pending_pix.push_back(typed_res);
	endtask

	function automatic logic [7:0] rand_pixel(input int base);
		int v;
		if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
		v = base + $urandom_range(0, 40) - 20;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// Whole frames with random content, plus a little noise and some cut-short frames.
	task automatic random_phase(input int n_items);
		int sent, w, h, base;
		bit cut;
		sent = 0;
		while (sent < n_items) begin
			w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
			set_reg(bf5_pkg::RegWidth, w | ($urandom_range(0, 3) << 11));
			set_reg(bf5_pkg::RegHeight, h);
			repeat ($urandom_range(1, 3)) begin
				cut = 0;
				base = $urandom_range(0, 255);
				for (int p = 0; p < w * h && !cut; p++) begin
					if ($urandom_range(0, 99) < 3) put(1'b1, 8'($urandom_range(0, 255)));
					put(1'b0, rand_pixel(base));
					sent++;
					if ($urandom_range(0, 999) < 4) cut = 1;
				end
				if (cut) break;
				for (int d = 0; d < 2 * w + 2; d++) begin
					put($urandom_range(0, 99) < 10 ? 1'b0 : 1'b1, 8'($urandom_range(0, 255)));
					sent++;
				end
			end
		end
	endtask

	task automatic full_frame(input int n_pix, input int n_drain);
		for (int p = 0; p < n_pix; p++) put(1'b0, rand_pixel(128));
		for (int d = 0; d < n_drain; d++) put(1'b1, 8'd0);
	endtask

	stim_row_t directed [23] = '{
		'{1, bf5_pkg::RegWidth, 1, 0, 0, 0, 0, 0},
		'{1, bf5_pkg::RegHeight, 1, 0, 0, 0, 0, 0},
		'{0, 0, 0, 1, 8'd9, 0, 0, 0},
		'{0, 0, 0, 0, 8'd200, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 1, 8'd200, 1'b1},
		'{0, 0, 0, 0, 8'd255, 0, 0, 0},
		'{0, 0, 0, 0, 8'd0, 0, 0, 0},
		'{0, 0, 0, 0, 8'd77, 0, 0, 0},
		'{0, 0, 0, 1, 8'hFF, 0, 0, 0},
		'{0, 0, 0, 1, 0, 1, 8'd255, 1'b1},
		'{1, bf5_pkg::RegWidth, 2, 0, 0, 0, 0, 0},
		'{1, bf5_pkg::RegHeight, 1, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 8'd0, 0, 0, 0},
		'{0, 0, 0, 0, 8'd255, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0},
		'{0, 0, 0, 1, 0, 0, 0, 0}
	};

	always @(posedge clk) begin
		pix_out_t want;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (pending_pix.size() == 0) begin
				$error("unexpected result: filtered_value %0d frame_last %0b",
					filtered_value, frame_last);
				errors++;
			end else begin
				want = pending_pix.pop_front();
				if (filtered_value !== want.value) begin
					$error("filtered_value: expected %0d, actual %0d", want.value,
						filtered_value);
					errors++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0b, actual %0b", want.last, frame_last);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		for (int d = 0; d < 9; d++) space_w[d] = gauss_q16(d, 25);
		for (int d = 0; d < 256; d++) range_w[d] = gauss_q16(d * d, 2500);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			if (directed[r].cfg) set_reg(directed[r].idx, directed[r].data);
			else put(directed[r].act, directed[r].pix, directed[r].typed,
				'{directed[r].exp_value, directed[r].exp_last});
		end

		// Register extremes: width above the maximum with height zero, where no result
		// can come yet, then width zero with height above the maximum.
		set_reg(bf5_pkg::RegWidth, 2047);
		set_reg(bf5_pkg::RegHeight, 0);
		full_frame(16, 1);
		set_reg(bf5_pkg::RegWidth, 0);
		set_reg(bf5_pkg::RegHeight, 8191);
		full_frame(64, 0);

		random_phase(280);
		send_idle_pct = 83;
		random_phase(280);
		send_idle_pct = 0;
		recv_stall_pct = 83;
		random_phase(280);
		send_idle_pct = 9;
		recv_stall_pct = 9;
		random_phase(280);

		wait_idle();
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/bf5_pkg.sv
sv/bf5_ram.sv
sv/bf5_datapath.sv
sv/bf5_ctrl.sv
sv/bilateral_filter_5x5_top.sv
dv/testbench.sv
